### hdl/adsr_envelope_generator_top_defines.svh
// ----------------------------------------------------------------------------
// ADSR envelope generator assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_TOP_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define ADSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ADSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared types and fixed-point constants for the envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

  localparam int LVL_W  = 17;   // Q1.16 level
  localparam int TIME_W = 13;
  localparam int COEF_W = 16;

  localparam logic [LVL_W-1:0]  FULL_SCALE = 17'd65536;
  localparam logic [TIME_W-1:0] TIME_MIN   = 13'd10;
  localparam logic [TIME_W-1:0] TIME_MAX   = 13'd5000;

  // register map, word index on paddr[4:2]
  typedef enum logic [2:0] {
    REG_ATTACK,
    REG_DECAY,
    REG_SUSTAIN,
    REG_RELEASE,
    REG_ENABLE,
    REG_COEFF
  } adsr_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0] attack_time_ms;
    logic [TIME_W-1:0] decay_time_ms;
    logic [LVL_W-1:0]  sustain_level;
    logic [TIME_W-1:0] release_time_ms;
    logic              envelope_enable;
    logic [COEF_W-1:0] smoothing_coeff;
  } adsr_cfg_t;

endpackage

`default_nettype wire

### hdl/adsr_cfg.sv
// ----------------------------------------------------------------------------
// ADSR configuration registers
// APB-style register file; writes complete in the access cycle, reads are
// combinational and pready is tied high.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output adsr_pkg::adsr_cfg_t    cfg
);
  import adsr_pkg::*;

  adsr_reg_t idx;
  logic      wr_en;

  assign idx    = adsr_reg_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_time_ms  <= TIME_MIN;
      cfg.decay_time_ms   <= TIME_MIN;
      cfg.sustain_level   <= '0;
      cfg.release_time_ms <= TIME_MIN;
      cfg.envelope_enable <= 1'b0;
      cfg.smoothing_coeff <= 16'd32768;
    end else if (wr_en) begin
      unique case (idx)
        REG_ATTACK:  cfg.attack_time_ms  <= pwdata[TIME_W-1:0];
        REG_DECAY:   cfg.decay_time_ms   <= pwdata[TIME_W-1:0];
        REG_SUSTAIN: cfg.sustain_level   <= pwdata[LVL_W-1:0];
        REG_RELEASE: cfg.release_time_ms <= pwdata[TIME_W-1:0];
        REG_ENABLE:  cfg.envelope_enable <= pwdata[0];
        REG_COEFF:   cfg.smoothing_coeff <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ATTACK:  prdata = 32'(cfg.attack_time_ms);
      REG_DECAY:   prdata = 32'(cfg.decay_time_ms);
      REG_SUSTAIN: prdata = 32'(cfg.sustain_level);
      REG_RELEASE: prdata = 32'(cfg.release_time_ms);
      REG_ENABLE:  prdata = 32'(cfg.envelope_enable);
      REG_COEFF:   prdata = 32'(cfg.smoothing_coeff);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/adsr_div.sv
// ----------------------------------------------------------------------------
// ADSR increment divider
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits QW bits, so only the low QW numerator bits are iterated.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_div #(
  parameter int NW = 36,
  parameter int DW = 30,
  parameter int QW = 14
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [QW-1:0] quo
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      trial;
  logic             fits;

  assign trial = {rem, quo[QW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= DW'(num >> QW);   // below den by construction
        quo  <= num[QW-1:0];
        dvs  <= den;
        cnt  <= CNT_W'(QW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
        quo <= {quo[QW-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/adsr_envelope_generator_top.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Linear attack/decay/sustain/release envelope with one-pole smoothing,
// advanced one control tick per input transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one transfer per control tick; s_tdata[0] key_held,
//   s_tdata[17:1] pressure (Q1.16).
//   m_* stream: one result per tick, m_tdata[16:0] amplitude (Q1.16).
//   APB port: six registers at byte addresses 0,4,..,20; write only while idle.
// Sequence: each tick runs from the input transfer through the states PROD,
//   DIVS, DIVW, STEP, FILT, SMTH and OUT to m_tvalid. In DIVW the restoring
//   divider, one quotient bit per cycle, forms the increment, a quotient of QW
//   bits (14 at the default parameters). s_tready is high only while the
//   sequencer is idle, so a new tick is not taken until the last has left OUT.
// Stall: the result sits in the output register until m_tready; a new tick
//   may be taken meanwhile and waits in its final stage for the register.
// Reset: level, phase, smoothed level and registers go to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adsr_envelope_generator_top_defines.svh"

module adsr_envelope_generator_top #(
  parameter int BLOCK_SIZE  = 256,
  parameter int SAMPLE_RATE = 48000
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // tdata: key_held [0], pressure [17:1]
  input  wire logic [23:0] s_tdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: amplitude [16:0]
  output logic      [23:0] m_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import adsr_pkg::*;

  localparam longint unsigned K_MUL   = 64'(BLOCK_SIZE) * 64'd250;
  localparam longint unsigned NUM_MAX = K_MUL * 64'd65536;
  localparam longint unsigned DEN_MAX = 64'(SAMPLE_RATE) * 64'd5000;
  localparam longint unsigned Q_MAX   = NUM_MAX / (64'(SAMPLE_RATE) * 64'd10);
  localparam int NW = $clog2(NUM_MAX + 64'd1);
  localparam int DW = $clog2(DEN_MAX + 64'd1);
  localparam int QW = $clog2(Q_MAX + 64'd1);
  localparam int CW = (QW > LVL_W + 1) ? QW : LVL_W + 1;
  localparam logic [NW-1:0] K_C  = NW'(K_MUL);
  localparam logic [DW-1:0] SR_C = DW'(SAMPLE_RATE);
  localparam logic [CW-1:0] FS_W = CW'(FULL_SCALE);

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_DIVS, S_DIVW, S_STEP, S_FILT, S_SMTH, S_OUT
  } state_t;

  state_t    state;
  adsr_cfg_t cfg;

  // per-tick registers
  logic              held;
  logic [LVL_W-1:0]  pressure;
  logic [NW-1:0]     num;
  logic [DW-1:0]     den;
  logic [LVL_W+COEF_W-1:0] prod;
  logic              up;
  logic [LVL_W-1:0]  amp;

  // envelope state
  logic [LVL_W-1:0]  level;
  logic              in_decay;
  logic              last_enable;
  logic [LVL_W-1:0]  smoothed_level;

  logic              div_done;
  logic [QW-1:0]     quo;

  logic [TIME_W-1:0] t_sel;
  logic [TIME_W-1:0] t_clamped;
  logic [LVL_W-1:0]  sus;
  logic [LVL_W-1:0]  span;
  logic [LVL_W-1:0]  level_next;
  logic              in_decay_next;
  logic [CW-1:0]     inc_w;
  logic [CW-1:0]     lvl_w;
  logic [CW-1:0]     sus_w;
  logic [LVL_W-1:0]  diff;
  logic [LVL_W-1:0]  corr;
  logic [LVL_W-1:0]  smoothed_next;
  logic              s_xfer;
  logic              out_free;

  adsr_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  adsr_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
    .clk, .rst,
    .start (state == S_DIVS),
    .num, .den,
    .done  (div_done),
    .quo
  );

  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign sus      = (cfg.sustain_level > FULL_SCALE) ? FULL_SCALE : cfg.sustain_level;

  // phase selects the time register and the span of the ramp
  always_comb begin
    if (!held) begin
      t_sel = cfg.release_time_ms;
      span  = FULL_SCALE;
    end else if (in_decay) begin
      t_sel = cfg.decay_time_ms;
      span  = FULL_SCALE - sus;
    end else begin
      t_sel = cfg.attack_time_ms;
      span  = FULL_SCALE;
    end
    if (t_sel < TIME_MIN) begin
      t_clamped = TIME_MIN;
    end else if (t_sel > TIME_MAX) begin
      t_clamped = TIME_MAX;
    end else begin
      t_clamped = t_sel;
    end
  end

  // envelope step, each move capped at its target; a change of enable zeroes the level
  always_comb begin
    inc_w         = CW'(quo);
    lvl_w         = CW'(level);
    sus_w         = CW'(sus);
    level_next    = level;
    in_decay_next = in_decay;
    if (!held) begin
      level_next    = (inc_w > lvl_w) ? '0 : LVL_W'(lvl_w - inc_w);
      in_decay_next = 1'b0;
    end else if (!in_decay) begin
      if (inc_w >= FS_W - lvl_w) begin
        level_next    = FULL_SCALE;
        in_decay_next = 1'b1;
      end else begin
        level_next = LVL_W'(lvl_w + inc_w);
      end
    end else if (lvl_w > sus_w) begin
      level_next = (inc_w > lvl_w - sus_w) ? sus : LVL_W'(lvl_w - inc_w);
    end else begin
      level_next = sus;
    end
    if (cfg.envelope_enable != last_enable) begin
      level_next = '0;
    end
  end

  assign diff = (level >= smoothed_level) ? level - smoothed_level
                                          : smoothed_level - level;
  assign corr = prod[LVL_W+COEF_W-1:COEF_W];
  assign smoothed_next = up ? smoothed_level + corr : smoothed_level - corr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      level          <= '0;
      in_decay       <= 1'b0;
      last_enable    <= 1'b0;
      smoothed_level <= '0;
    end else begin
      if (state == S_OUT && out_free) begin
        m_tdata  <= 24'(amp);
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_xfer) begin
            held     <= s_tdata[0];
            pressure <= s_tdata[LVL_W:1];
            state    <= S_PROD;
          end
        end
        S_PROD: begin
          num   <= K_C * NW'(span);
          den   <= SR_C * DW'(t_clamped);
          state <= S_DIVS;
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          level       <= level_next;
          in_decay    <= in_decay_next;
          last_enable <= cfg.envelope_enable;
          state       <= S_FILT;
        end
        S_FILT: begin
          up    <= level >= smoothed_level;
          prod  <= diff * cfg.smoothing_coeff;
          state <= S_SMTH;
        end
        S_SMTH: begin
          if (cfg.envelope_enable) begin
            smoothed_level <= smoothed_next;
            amp            <= smoothed_next;
          end else begin
            amp <= (pressure > FULL_SCALE) ? FULL_SCALE : pressure;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ADSR_ASSERT_IMP(a_level_range, 1'b1, level <= FULL_SCALE, "level above full scale")
  `ADSR_ASSERT_IMP(a_smooth_range, 1'b1, smoothed_level <= FULL_SCALE, "smoothed level high")
  `ADSR_ASSERT_NXT(a_accept_start, s_xfer, state == S_PROD, "accepted tick did not start")
  `ADSR_ASSERT_IMP(a_div_done_state, div_done, state == S_DIVW, "divider done outside wait")

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ADSR envelope generator testbench
// Drives control ticks on the input stream and register writes on the APB
// port, predicts every amplitude with a cycle-free model of the envelope,
// attack/decay/sustain/release plus one-pole smoothing, and checks the output
// stream in order under random source and sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import adsr_pkg::*;

  localparam int ENV_BLOCK_SIZE  = 256;
  localparam int ENV_SAMPLE_RATE = 48000;
  localparam int NUM_PHASES      = 9;
  localparam int PHASE_TICKS     = 115;
  localparam int SETTLE_CYCLES   = 32;
  localparam int STALL_LIMIT     = 5000;
  localparam logic [4:0] UNMAPPED_ADDR = 5'd24;

  typedef struct packed {
    logic [LVL_W-1:0] pressure;
    logic             key_held;
  } tick_t;

  // --------------------------------------------------------------------------
  class envelope_scoreboard;
    logic [TIME_W-1:0] attack_ms, decay_ms, release_ms;
    logic [LVL_W-1:0]  sustain;
    logic              enable;
    logic [COEF_W-1:0] coeff;
    int unsigned       level, smoothed;
    bit                in_decay, last_enable;
    logic [LVL_W-1:0]  amplitude_q[$];
    int unsigned       mismatches, checked, ticks;

    function new();
      attack_ms   = 13'd10;
      decay_ms    = 13'd10;
      sustain     = '0;
      release_ms  = 13'd10;
      enable      = 1'b0;
      coeff       = 16'd32768;
      level       = 0;
      smoothed    = 0;
      in_decay    = 1'b0;
      last_enable = 1'b0;
    endfunction

    function void write_reg(logic [4:0] addr, logic [31:0] data);
      case (adsr_reg_t'(addr[4:2]))
        REG_ATTACK:  attack_ms  = data[TIME_W-1:0];
        REG_DECAY:   decay_ms   = data[TIME_W-1:0];
        REG_SUSTAIN: sustain    = data[LVL_W-1:0];
        REG_RELEASE: release_ms = data[TIME_W-1:0];
        REG_ENABLE:  enable     = data[0];
        REG_COEFF:   coeff      = data[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    // per-tick slope for a move of span over ms milliseconds, truncated
    function int unsigned step_size(logic [TIME_W-1:0] ms, int unsigned span);
      longint unsigned t, num;
      t = (ms < TIME_MIN) ? TIME_MIN : (ms > TIME_MAX) ? TIME_MAX : ms;
      num = longint'(ENV_BLOCK_SIZE) * 250 * span;
      return int'(num / (longint'(ENV_SAMPLE_RATE) * t));
    endfunction

    function void note_tick(tick_t t);
      int unsigned     sus, inc, amp;
      longint unsigned d;
      sus = (sustain > FULL_SCALE) ? FULL_SCALE : sustain;
      if (t.key_held) begin
        if (!in_decay) begin
          inc = step_size(attack_ms, FULL_SCALE);
          if (inc > FULL_SCALE - level) inc = FULL_SCALE - level;
          level += inc;
          if (level >= FULL_SCALE) begin
            level = FULL_SCALE;
            in_decay = 1'b1;
          end
        end else begin
          inc = step_size(decay_ms, FULL_SCALE - sus);
          if (level > sus) begin
            if (inc > level - sus) inc = level - sus;
            level -= inc;
          end else begin
            level = sus;
          end
        end
      end else begin
        inc = step_size(release_ms, FULL_SCALE);
        if (inc > level) inc = level;
        level -= inc;
        in_decay = 1'b0;
      end

      if (enable) begin
        if (!last_enable) begin
          level = 0;
          last_enable = 1'b1;
        end
        if (level >= smoothed) begin
          d = longint'(level - smoothed) * coeff;
          smoothed += int'(d >> 16);
        end else begin
          d = longint'(smoothed - level) * coeff;
          smoothed -= int'(d >> 16);
        end
        amp = smoothed;
      end else begin
        if (last_enable) begin
          level = 0;
          last_enable = 1'b0;
        end
        amp = t.pressure;
      end
      if (amp > FULL_SCALE) amp = FULL_SCALE;
      amplitude_q.push_back(amp[LVL_W-1:0]);
      ticks++;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_amplitude(logic [LVL_W-1:0] got);
      logic [LVL_W-1:0] want;
      if (amplitude_q.size() == 0) begin
        report_mismatch($sformatf("amplitude %0d with no tick pending", got));
      end else begin
        want = amplitude_q.pop_front();
        checked++;
        if (got !== want)
          report_mismatch($sformatf("amplitude %0d, predicted %0d", got, want));
      end
    endtask
  endclass
  // --------------------------------------------------------------------------

  logic        clk = 1'b0;
  logic        rst;
  logic [23:0] s_tdata;     // key_held [0], pressure [17:1]
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] m_tdata;     // amplitude [16:0]
  logic        m_tvalid;
  logic        m_tready;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  envelope_scoreboard envelope_sb;
  int unsigned send_idle, recv_idle;
  int unsigned reg_writes;
  int unsigned quiet_cycles;

  adsr_envelope_generator_top #(
    .BLOCK_SIZE  (ENV_BLOCK_SIZE),
    .SAMPLE_RATE (ENV_SAMPLE_RATE)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // output side: random back-pressure and in-order checking
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
    if (!rst && m_tvalid && m_tready)
      envelope_sb.check_amplitude(m_tdata[LVL_W-1:0]);
  end

  // stall watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task apb_write(logic [4:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    envelope_sb.write_reg(addr, data);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task write_reg(adsr_reg_t r, logic [31:0] data);
    apb_write({r, 2'b00}, data);
  endtask

  task send_tick(bit held, logic [LVL_W-1:0] pressure);
    tick_t t;
    t.key_held = held;
    t.pressure = pressure;
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, t};
    do @(posedge clk); while (!s_tready);
    envelope_sb.note_tick(t);
  endtask

  // hold the source off until every pending amplitude is out, then settle
  task drain_ticks();
    s_tvalid <= 1'b0;
    while (envelope_sb.amplitude_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(9))
      0:       return $urandom_range(9);
      1:       return 10;
      2:       return 5000;
      3:       return $urandom_range(8191);
      default: return $urandom_range(10, 120);
    endcase
  endfunction

  function automatic logic [31:0] pick_pressure();
    case ($urandom_range(9))
      0:       return 0;
      1:       return FULL_SCALE;
      default: return $urandom_range(131071);
    endcase
  endfunction

  task configure_phase(int p);
    logic [31:0] atk, dec, rel, sus, coef;
    logic        en;
    atk  = pick_time();
    dec  = pick_time();
    rel  = pick_time();
    sus  = ($urandom_range(3) == 0) ? $urandom_range(131071) : $urandom_range(65536);
    coef = $urandom_range(65535);
    en   = ($urandom_range(9) < 7);
    case (p)
      1: begin
        atk = 0; dec = 8191; rel = 5000; sus = 131071; coef = 65535; en = 1'b1;
      end
      2: begin
        atk = 5000; dec = 10; rel = 3; sus = 0; coef = 0; en = 1'b1;
      end
      3: begin
        sus = 65536; en = 1'b0;
      end
      default: ;
    endcase
    write_reg(REG_ATTACK, atk);
    write_reg(REG_DECAY, dec);
    write_reg(REG_SUSTAIN, sus);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_COEFF, coef);
    write_reg(REG_ENABLE, en);
  endtask

  task run_phase(int count);
    int  n;
    int  hold_len, rel_len;
    bit  paused;
    n = 0;
    paused = 1'b0;
    while (n < count) begin
      if (!paused && n >= count / 2) begin
        drain_ticks();
        paused = 1'b1;
      end
      if ($urandom_range(9) < 8) begin
        // press, hold, then let go
        hold_len = $urandom_range(4, 40);
        rel_len  = $urandom_range(2, 20);
        repeat (hold_len) send_tick(1'b1, pick_pressure());
        repeat (rel_len) send_tick(1'b0, pick_pressure());
        n += hold_len + rel_len;
      end else begin
        hold_len = $urandom_range(1, 6);
        repeat (hold_len) send_tick($urandom_range(1), pick_pressure());
        n += hold_len;
      end
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    send_idle  = 28;
    recv_idle  = 48;
    reg_writes = 0;
    envelope_sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // passthrough at reset settings, pressure extremes and saturation
    send_tick(1'b0, 17'd0);
    send_tick(1'b1, FULL_SCALE);
    send_tick(1'b0, 17'h1FFFF);
    send_tick(1'b1, 17'h15555);
    send_tick(1'b0, 17'h0AAAA);
    drain_ticks();

    // enable with fast times: full attack, decay onto sustain, hold, release
    apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    write_reg(REG_SUSTAIN, 40000);
    write_reg(REG_COEFF, 65535);
    write_reg(REG_ENABLE, 1);
    repeat (18) send_tick(1'b1, $urandom_range(131071));
    repeat (3) send_tick(1'b0, $urandom_range(131071));
    drain_ticks();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0: begin send_idle = 28; recv_idle = 48; end
        1: begin send_idle = 48; recv_idle = 28; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      configure_phase(p);
      run_phase(PHASE_TICKS);
      drain_ticks();
    end

    $display("Run covered %0d ticks and %0d checked amplitudes over %0d register writes,",
             envelope_sb.ticks, envelope_sb.checked, reg_writes);
    $display("with passthrough, full envelopes, time and sustain clamps and smoothing extremes.");
    if (envelope_sb.mismatches == 0 && envelope_sb.amplitude_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
